// ----- rtl/i2cee_pkg.sv -----
// Shared types and codes for the I2C EEPROM bit-bang master.
`default_nettype none

package i2cee_pkg;

    localparam int PHASE_W = 16;
    localparam int WAIT_W  = 24;
    localparam int CFG_W   = 24;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic CFG_PHASE_TICKS      = 1'b0;
    localparam logic CFG_WRITE_WAIT_TICKS = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd125;
    localparam logic [WAIT_W-1:0]  WAIT_TICKS_RST  = 24'd10000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  slave_address;
        logic [15:0] memory_address;
        logic [7:0]  write_byte;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       nack_seen;
        logic [2:0] nack_byte;
        logic [7:0] read_byte;
    } t_out_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [WAIT_W-1:0]  write_wait_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/i2cee_seq.sv -----
// Bus sequencer: advances START/byte/ACK/read/STOP phases one item at a time.
`default_nettype none

module i2cee_seq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire i2cee_pkg::t_in_item i_item,
    input  wire i2cee_pkg::t_cfg     i_cfg,
    output i2cee_pkg::t_out_item o_result
);

    typedef enum logic [4:0] {
        S_IDLE, S_ST1, S_ST2, S_ST3, S_BIT1, S_BIT2, S_BIT3,
        S_ACK1, S_ACK2, S_ACK3, S_RX1, S_RX2, S_RN1, S_RN2, S_RN3,
        S_SP1, S_SP2, S_SP3, S_WAIT
    } t_state;

    t_state                          r_state, n_state;
    logic [3:0]                      r_bit_cnt, n_bit_cnt;
    logic [1:0]                      r_byte_idx, n_byte_idx;
    logic [7:0]                      r_shift, n_shift;
    logic [i2cee_pkg::PHASE_W-1:0]   r_phase, n_phase;
    logic [i2cee_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic                            r_is_read, n_is_read;
    logic [6:0]                      r_slave, n_slave;
    logic [15:0]                     r_mem_addr, n_mem_addr;
    logic [7:0]                      r_data, n_data;
    logic                            r_nack, n_nack;
    logic                            r_scl, n_scl;
    logic                            r_sda, n_sda;
    logic                            r_drv, n_drv;
    logic                            n_done;

    // byte sent at each position of the transfer
    function automatic logic [7:0] f_byte(input logic [1:0] idx, input logic is_read,
                                          input logic [6:0] slave, input logic [15:0] addr,
                                          input logic [7:0] data);
        logic [7:0] b;
        case (idx)
            2'd0:    b = {slave, 1'b0};
            2'd1:    b = addr[15:8];
            2'd2:    b = addr[7:0];
            default: b = is_read ? {slave, 1'b1} : data;
        endcase
        return b;
    endfunction

    always_comb begin
        logic [i2cee_pkg::PHASE_W-1:0] v_limit;
        logic [i2cee_pkg::PHASE_W-1:0] v_phase;
        logic [3:0]                    v_bits;
        logic [7:0]                    v_byte;

        n_state    = r_state;
        n_bit_cnt  = r_bit_cnt;
        n_byte_idx = r_byte_idx;
        n_shift    = r_shift;
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_is_read  = r_is_read;
        n_slave    = r_slave;
        n_mem_addr = r_mem_addr;
        n_data     = r_data;
        n_nack     = r_nack;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_drv      = r_drv;
        n_done     = 1'b0;

        v_limit = (i_cfg.phase_ticks == '0) ? i2cee_pkg::PHASE_W'(1) : i_cfg.phase_ticks;
        v_phase = r_phase + i2cee_pkg::PHASE_W'(1);
        v_bits  = r_bit_cnt + 4'd1;
        v_byte  = f_byte(r_byte_idx + 2'd1, r_is_read, r_slave, r_mem_addr, r_data);

        if (i_item.kind == i2cee_pkg::KIND_TICK) begin
            if (r_state == S_WAIT) begin
                n_wait = r_wait + i2cee_pkg::WAIT_W'(1);
                if (n_wait >= i_cfg.write_wait_ticks) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end else if (r_state != S_IDLE) begin
                n_phase = v_phase;
                if (v_phase >= v_limit) begin
                    n_phase = '0;
                    case (r_state)
                        S_ST1: begin
                            n_scl   = 1'b1;
                            n_state = S_ST2;
                        end
                        S_ST2: begin
                            n_sda   = 1'b0;
                            n_state = S_ST3;
                        end
                        S_ST3: begin
                            v_byte    = f_byte(r_byte_idx, r_is_read, r_slave,
                                               r_mem_addr, r_data);
                            n_scl     = 1'b0;
                            n_bit_cnt = 4'd0;
                            n_drv     = 1'b1;
                            n_sda     = v_byte[7];
                            n_shift   = {v_byte[6:0], 1'b0};
                            n_state   = S_BIT1;
                        end
                        S_BIT1: begin
                            n_scl   = 1'b1;
                            n_state = S_BIT2;
                        end
                        S_BIT2: begin
                            n_scl   = 1'b0;
                            n_state = S_BIT3;
                        end
                        S_BIT3: begin
                            n_bit_cnt = v_bits;
                            if (v_bits < 4'd8) begin
                                n_drv   = 1'b1;
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_state = S_BIT1;
                            end else begin
                                n_drv   = 1'b0;
                                n_state = S_ACK1;
                            end
                        end
                        S_ACK1: begin
                            n_scl   = 1'b1;
                            n_state = S_ACK2;
                        end
                        S_ACK2: begin
                            n_nack  = i_item.sda_in;
                            n_scl   = 1'b0;
                            n_state = S_ACK3;
                        end
                        S_ACK3: begin
                            n_drv = 1'b1;
                            if (r_nack) begin
                                n_sda   = 1'b0;
                                n_state = S_SP1;
                            end else if (r_is_read && r_byte_idx == 2'd2) begin
                                // repeated START before address+R
                                n_byte_idx = 2'd3;
                                n_sda      = 1'b1;
                                n_state    = S_ST1;
                            end else if (r_is_read && r_byte_idx == 2'd3) begin
                                n_drv     = 1'b0;
                                n_shift   = '0;
                                n_bit_cnt = 4'd0;
                                n_scl     = 1'b1;
                                n_state   = S_RX1;
                            end else if (r_byte_idx != 2'd3) begin
                                n_byte_idx = r_byte_idx + 2'd1;
                                n_bit_cnt  = 4'd0;
                                n_sda      = v_byte[7];
                                n_shift    = {v_byte[6:0], 1'b0};
                                n_state    = S_BIT1;
                            end else begin
                                n_sda   = 1'b0;
                                n_state = S_SP1;
                            end
                        end
                        S_RX1: begin
                            n_shift = {r_shift[6:0], i_item.sda_in};
                            n_scl   = 1'b0;
                            n_state = S_RX2;
                        end
                        S_RX2: begin
                            n_bit_cnt = v_bits;
                            if (v_bits < 4'd8) begin
                                n_scl   = 1'b1;
                                n_state = S_RX1;
                            end else begin
                                // answer NACK
                                n_drv   = 1'b1;
                                n_sda   = 1'b1;
                                n_state = S_RN1;
                            end
                        end
                        S_RN1: begin
                            n_scl   = 1'b1;
                            n_state = S_RN2;
                        end
                        S_RN2: begin
                            n_scl   = 1'b0;
                            n_state = S_RN3;
                        end
                        S_RN3: begin
                            n_drv   = 1'b1;
                            n_sda   = 1'b0;
                            n_state = S_SP1;
                        end
                        S_SP1: begin
                            n_scl   = 1'b1;
                            n_state = S_SP2;
                        end
                        S_SP2: begin
                            n_sda   = 1'b1;
                            n_state = S_SP3;
                        end
                        S_SP3: begin
                            // phase counter is advanced, not cleared, on both exits
                            n_phase = v_phase;
                            if (!r_is_read && !r_nack && i_cfg.write_wait_ticks != '0) begin
                                n_wait  = '0;
                                n_state = S_WAIT;
                            end else begin
                                n_state = S_IDLE;
                                n_done  = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = v_phase;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
        end else if ((i_item.kind == i2cee_pkg::KIND_WRITE ||
                      i_item.kind == i2cee_pkg::KIND_READ) && r_state == S_IDLE) begin
            n_is_read  = (i_item.kind == i2cee_pkg::KIND_READ);
            n_slave    = i_item.slave_address;
            n_mem_addr = i_item.memory_address;
            n_data     = i_item.write_byte;
            n_nack     = 1'b0;
            n_byte_idx = 2'd0;
            n_bit_cnt  = 4'd0;
            n_drv      = 1'b1;
            n_sda      = 1'b1;
            n_phase    = '0;
            n_state    = S_ST1;
        end
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.sda_drive = n_drv;
        o_result.busy_res  = (n_state != S_IDLE);
        o_result.done_res  = n_done;
        o_result.nack_seen = n_done & n_nack;
        o_result.nack_byte = (n_done && n_nack) ? {1'b0, n_byte_idx} : 3'd0;
        o_result.read_byte = (n_done && n_is_read && !n_nack) ? n_shift : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bit_cnt  <= '0;
            r_byte_idx <= '0;
            r_shift    <= '0;
            r_phase    <= '0;
            r_wait     <= '0;
            r_is_read  <= 1'b0;
            r_slave    <= '0;
            r_mem_addr <= '0;
            r_data     <= '0;
            r_nack     <= 1'b0;
            r_scl      <= 1'b1;
            r_sda      <= 1'b1;
            r_drv      <= 1'b1;
        end else if (i_step) begin
            r_state    <= n_state;
            r_bit_cnt  <= n_bit_cnt;
            r_byte_idx <= n_byte_idx;
            r_shift    <= n_shift;
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_is_read  <= n_is_read;
            r_slave    <= n_slave;
            r_mem_addr <= n_mem_addr;
            r_data     <= n_data;
            r_nack     <= n_nack;
            r_scl      <= n_scl;
            r_sda      <= n_sda;
            r_drv      <= n_drv;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/i2c_eeprom_bitbang_master.sv -----
// Top level of the I2C EEPROM bit-bang master: handshake, config registers, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Every accepted item (command or tick) yields exactly one result, registered in the cycle after it is accepted.
// One item per cycle while the input is not stalled: the sequencer step is a single pass into the result register.
// The input is stalled only while a result is held and the output is stalled.
// Reset (synchronous, active low) leaves the bus idle: SCL high, SDA driven high.
// Config writes take effect on the next item.
`default_nettype none

module i2c_eeprom_bitbang_master (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire i2cee_pkg::t_in_item i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output i2cee_pkg::t_out_item o_out_data,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire [i2cee_pkg::CFG_W-1:0] i_cfg_data
);

    i2cee_pkg::t_cfg      r_cfg;
    i2cee_pkg::t_out_item n_result;
    i2cee_pkg::t_out_item r_out_data;
    logic                 r_out_valid;
    logic                 step;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign step        = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks      <= i2cee_pkg::PHASE_TICKS_RST;
            r_cfg.write_wait_ticks <= i2cee_pkg::WAIT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cee_pkg::CFG_PHASE_TICKS:
                    r_cfg.phase_ticks <= i_cfg_data[i2cee_pkg::PHASE_W-1:0];
                i2cee_pkg::CFG_WRITE_WAIT_TICKS:
                    r_cfg.write_wait_ticks <= i_cfg_data[i2cee_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    i2cee_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (n_result)
    );

    // hold the result while the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= n_result;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.done_res |-> !r_out_data.busy_res)
        else $error("done reported while still busy");

    a_nack_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.nack_seen |-> r_out_data.done_res)
        else $error("nack flag without done");

    a_read_byte_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.read_byte != 8'd0 |->
            r_out_data.done_res && !r_out_data.nack_seen)
        else $error("read byte outside a good read completion");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
